@@ hdl/cdb_pkg.sv @@
// Package with payload types and step functions for the constant deceleration brake core.
package cdb_pkg;

	localparam int unsigned SQRT_STEPS = 24;
	localparam int unsigned DIV_STEPS  = 40;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TARGET   = 2'd1;
	localparam logic [1:0] ERR_DISTANCE = 2'd2;
	localparam logic [1:0] ERR_DECEL    = 2'd3;

	localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        req_type;
		logic [23:0] start_speed;
		logic [23:0] goal_speed;
		logic [31:0] brake_distance;
	} req_t;

	typedef struct packed {
		logic [39:0] brake_time;
		logic [23:0] end_speed;
		logic [31:0] covered_distance;
		logic        stopped_early;
		logic [1:0]  error_code;
	} result_t;

	// Per-item context that travels down the whole pipeline.
	typedef struct packed {
		logic        mode;
		logic [1:0]  err;
		logic        early;
		logic [20:0] amag;
		logic [23:0] v0;
		logic [23:0] vt;
		logic [31:0] d;
	} ctx_t;

	typedef struct packed {
		logic [47:0] rad;
		logic [25:0] rem;
		logic [23:0] root;
	} sqt_t;

	typedef struct packed {
		logic [39:0] num;
		logic [20:0] rem;
		logic [39:0] q;
	} div_t;

	// One digit of a restoring square root.
	function automatic sqt_t sqrt_step(sqt_t a);
		logic [27:0] r;
		logic [27:0] t;
		sqt_t        b;
		r     = {a.rem, a.rad[47:46]};
		t     = {2'b00, a.root, 2'b01};
		b.rad = {a.rad[45:0], 2'b00};
		if (r >= t) begin
			b.rem  = 26'(r - t);
			b.root = {a.root[22:0], 1'b1};
		end else begin
			b.rem  = r[25:0];
			b.root = {a.root[22:0], 1'b0};
		end
		return b;
	endfunction

	// One quotient bit of a restoring divide.
	function automatic div_t div_step(div_t a, logic [20:0] den);
		logic [21:0] r;
		div_t        b;
		r     = {a.rem, a.num[39]};
		b.num = {a.num[38:0], 1'b0};
		if (r >= {1'b0, den}) begin
			b.rem = 21'(r - {1'b0, den});
			b.q   = {a.q[38:0], 1'b1};
		end else begin
			b.rem = r[20:0];
			b.q   = {a.q[38:0], 1'b0};
		end
		return b;
	endfunction

endpackage

@@ hdl/constant_deceleration_brake_core.sv @@
// Top level of the constant deceleration braking calculator.
//
// Channel   Signals                          Handshake
// request   start, busy, req                 accepted when start is high and busy is low
// result    done, result                     done marks one cycle, no back pressure
// config    cfg_valid, cfg_ready, cfg_data   written when cfg_valid and cfg_ready are high
//
// A request is accepted in every cycle; busy is always low. Each result passes
// through one input stage, one multiply stage, one setup stage, 24 square root
// stages, one stage that forms the speed loss, 40 divide stages and the output
// register. The divide chain is the longest part of the pipeline. Reset clears
// the valid bits and loads the deceleration register with -1 m/s^2. The receiver
// cannot stall, so the pipeline never holds.
module constant_deceleration_brake_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  cdb_pkg::req_t           req,
	output logic                    done,
	output cdb_pkg::result_t        result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [20:0]             cfg_data
);

	localparam int unsigned NS = cdb_pkg::SQRT_STEPS;
	localparam int unsigned ND = cdb_pkg::DIV_STEPS;

	logic [20:0] decel_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decel_q <= 21'h1F_0000;
		end else if (cfg_valid && cfg_ready) begin
			decel_q <= cfg_data;
		end
	end

	// Stage 1: capture the request, the magnitude of the deceleration and
	// the precondition checks. The deceleration is taken with the item, so a
	// later register write does not disturb items in flight.
	logic          v_s1;
	cdb_pkg::ctx_t ctx_s1;
	cdb_pkg::ctx_t ctx_in;

	always_comb begin
		ctx_in.mode  = req.req_type;
		ctx_in.v0    = req.start_speed;
		ctx_in.vt    = req.goal_speed;
		ctx_in.d     = req.brake_distance;
		ctx_in.amag  = 21'(22'h20_0000 - {1'b0, decel_q});
		ctx_in.early = 1'b0;
		priority if (!decel_q[20]) begin
			ctx_in.err = cdb_pkg::ERR_DECEL;
		end else if (!req.req_type && (req.start_speed <= req.goal_speed)) begin
			ctx_in.err = cdb_pkg::ERR_TARGET;
		end else if (req.req_type && (req.brake_distance == 32'd0)) begin
			ctx_in.err = cdb_pkg::ERR_DISTANCE;
		end else begin
			ctx_in.err = cdb_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_in;
	end

	// Stage 2: the squares of both speeds and the energy lost over the distance.
	logic          v_s2;
	cdb_pkg::ctx_t ctx_s2;
	logic [47:0]   sq_s2;
	logic [47:0]   vt2_s2;
	logic [52:0]   ad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		sq_s2  <= 48'(ctx_s1.v0) * 48'(ctx_s1.v0);
		vt2_s2 <= 48'(ctx_s1.vt) * 48'(ctx_s1.vt);
		ad_s2  <= 53'(ctx_s1.amag) * 53'(ctx_s1.d);
	end

	// Stage 3: decide whether the train stops early, form the radicand and the
	// distance numerator. The distance divisor's factor of 512 is folded into
	// the numerator, which floors the same way.
	logic          v_s3;
	cdb_pkg::ctx_t ctx_s3;
	logic [39:0]   dnum_s3;
	logic [47:0]   rad_s3;
	logic [61:0]   loss;
	logic          early;
	logic [47:0]   dsq;
	cdb_pkg::ctx_t ctx_e;

	assign loss  = {ad_s2, 9'd0};
	assign early = ctx_s2.mode && (loss > 62'(sq_s2));
	assign dsq   = (ctx_s2.mode) ? sq_s2 : 48'(sq_s2 - vt2_s2);

	always_comb begin
		ctx_e       = ctx_s2;
		ctx_e.early = early;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3       <= ctx_e;
		dnum_s3      <= {1'b0, dsq[47:9]};
		rad_s3       <= (ctx_s2.mode && !early) ? 48'(62'(sq_s2) - loss) : 48'd0;
	end

	// Square root stages, one result bit each.
	logic          v_sr_s   [0:NS];
	cdb_pkg::ctx_t ctx_sr_s [0:NS];
	logic [39:0]   dnum_sr_s[0:NS];
	cdb_pkg::sqt_t sqt_s    [0:NS];

	always_comb begin
		v_sr_s[0]    = v_s3;
		ctx_sr_s[0]  = ctx_s3;
		dnum_sr_s[0] = dnum_s3;
		sqt_s[0].rad  = rad_s3;
		sqt_s[0].rem  = '0;
		sqt_s[0].root = '0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sr_s[i+1] <= 1'b0;
			end else begin
				v_sr_s[i+1] <= v_sr_s[i];
			end
		end

		always_ff @(posedge clk) begin
			ctx_sr_s[i+1]  <= ctx_sr_s[i];
			dnum_sr_s[i+1] <= dnum_sr_s[i];
			sqt_s[i+1]     <= cdb_pkg::sqrt_step(sqt_s[i]);
		end
	end

	// Speed stage: pick the end speed and the speed lost.
	logic          v_sp_s;
	cdb_pkg::ctx_t ctx_sp_s;
	logic [39:0]   dnum_sp_s;
	logic [23:0]   ve_sp_s;
	logic [23:0]   dv_sp_s;
	logic [23:0]   ve;
	cdb_pkg::ctx_t cx;

	assign cx = ctx_sr_s[NS];

	always_comb begin
		priority if (!cx.mode) begin
			ve = cx.vt;
		end else if (cx.early) begin
			ve = 24'd0;
		end else begin
			ve = sqt_s[NS].root;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp_s <= 1'b0;
		end else begin
			v_sp_s <= v_sr_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		ctx_sp_s  <= cx;
		dnum_sp_s <= dnum_sr_s[NS];
		ve_sp_s   <= ve;
		dv_sp_s   <= cx.v0 - ve;
	end

	// Divide stages: time and distance quotients side by side.
	logic          v_dv_s  [0:ND];
	cdb_pkg::ctx_t ctx_dv_s[0:ND];
	logic [23:0]   ve_dv_s [0:ND];
	cdb_pkg::div_t tdiv_s  [0:ND];
	cdb_pkg::div_t ddiv_s  [0:ND];

	always_comb begin
		v_dv_s[0]     = v_sp_s;
		ctx_dv_s[0]   = ctx_sp_s;
		ve_dv_s[0]    = ve_sp_s;
		tdiv_s[0].num = {dv_sp_s, 16'd0};
		tdiv_s[0].rem = '0;
		tdiv_s[0].q   = '0;
		ddiv_s[0].num = dnum_sp_s;
		ddiv_s[0].rem = '0;
		ddiv_s[0].q   = '0;
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv_s[j+1] <= 1'b0;
			end else begin
				v_dv_s[j+1] <= v_dv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			ctx_dv_s[j+1] <= ctx_dv_s[j];
			ve_dv_s[j+1]  <= ve_dv_s[j];
			tdiv_s[j+1]   <= cdb_pkg::div_step(tdiv_s[j], ctx_dv_s[j].amag);
			ddiv_s[j+1]   <= cdb_pkg::div_step(ddiv_s[j], ctx_dv_s[j].amag);
		end
	end

	// Output register: saturate the distance and, on an error, zero every result field but the error code.
	cdb_pkg::ctx_t    cf;
	cdb_pkg::result_t res_d;

	assign cf = ctx_dv_s[ND];

	always_comb begin
		res_d.error_code    = cf.err;
		res_d.brake_time    = tdiv_s[ND].q;
		res_d.end_speed     = ve_dv_s[ND];
		res_d.stopped_early = cf.mode && cf.early;
		if (cf.mode && !cf.early) begin
			res_d.covered_distance = cf.d;
		end else if (ddiv_s[ND].q[39:32] != 8'd0) begin
			res_d.covered_distance = cdb_pkg::DIST_MAX;
		end else begin
			res_d.covered_distance = ddiv_s[ND].q[31:0];
		end
		if (cf.err != cdb_pkg::ERR_NONE) begin
			res_d.brake_time       = '0;
			res_d.end_speed        = '0;
			res_d.covered_distance = '0;
			res_d.stopped_early    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_dv_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

endmodule
